// ===== hdl/multi_stack_queue_store_macros.svh =====
// Assertion macros shared by the store block
`ifndef MULTI_STACK_QUEUE_STORE_MACROS_SVH
`define MULTI_STACK_QUEUE_STORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define MSQS_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("%m: check failed");

// Check that a condition implies a consequence in the next cycle
`define MSQS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

// ===== hdl/msqs_pkg.sv =====
// Types and constants of the multiple stack and queue store
package msqs_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int STORE_DEPTH = 256;
    localparam int STORE_COUNT = 27;
    localparam int QUEUE_SLOT  = 21;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int STORE_W     = 5;
    localparam int CNT_W       = POS_W + 1;
    localparam int MEM_DEPTH   = STORE_COUNT * STORE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        CMD_POP    = 3'd0,
        CMD_PUSH   = 3'd1,
        CMD_DUP    = 3'd2,
        CMD_SWAP   = 3'd3,
        CMD_SELECT = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_BAD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP2,
        ST_SWAP3
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic signed [31:0] value;
        logic [4:0]        store_choice;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic              value_valid;
        logic [1:0]        status;
        logic [8:0]        fill_count;
    } t_out;

endpackage

// ===== hdl/msqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module msqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/multi_stack_queue_store.sv =====
// Top level: stacks and one queue kept in one shared entry memory
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  command  | start / busy       | i_cmd   (command, value, store_choice)
//  result   | o_done, one cycle  | o_result (value_res, value_valid,
//           |                    |           status, fill_count)
//
// A command reads the entry memory in the accept cycle, modifies and writes
// back in the next cycle; the result shows the cycle after.
// A swap on two or more entries goes on through ST_SWAP2 and ST_SWAP3: one read
// port means a second read, then two writes.
// Reset is synchronous: counts, queue head and selection go to zero; the
// entry memory is not cleared, entries are read only below the fill count.
// The receiver cannot stall; busy stays high until the result transfer.
`include "multi_stack_queue_store_macros.svh"

module multi_stack_queue_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  msqs_pkg::t_in  i_cmd,
    output logic          o_done,
    output msqs_pkg::t_out o_result
);
    import msqs_pkg::*;

    t_state                  r_state, n_state;
    t_in                     r_in;
    logic [CNT_W-1:0]        r_counts [STORE_COUNT];
    logic [CNT_W-1:0]        n_counts [STORE_COUNT];
    logic [POS_W-1:0]        r_head, n_head;
    logic [STORE_W-1:0]      r_sel, n_sel;
    logic [ADDR_W-1:0]       r_addr_a, r_addr_b, r_addr_w;
    logic [VALUE_WIDTH-1:0]  r_hold, n_hold;
    logic                    r_done, n_done;
    logic [VALUE_WIDTH-1:0]  r_res, n_res;
    logic                    r_valid, n_valid;
    logic [1:0]              r_status, n_status;

    logic                    accept;
    logic [CNT_W-1:0]        cnt, cnt_m1, cnt_m2;
    logic                    is_queue;
    logic [POS_W-1:0]        pos_top, pos_second, pos_wr;
    logic [ADDR_W-1:0]       addr_a, addr_b, addr_w;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0]  mem_wdata, mem_rdata;

    assign accept = start && !busy;

    // locate top, second and write positions of the selected store
    always_comb begin
        cnt      = r_counts[r_sel];
        cnt_m1   = cnt - CNT_W'(1);
        cnt_m2   = cnt - CNT_W'(2);
        is_queue = (r_sel == STORE_W'(QUEUE_SLOT));
        pos_top    = is_queue ? r_head : cnt_m1[POS_W-1:0];
        pos_second = is_queue ? r_head + POS_W'(1) : cnt_m2[POS_W-1:0];
        if (i_cmd.command == CMD_DUP) begin
            pos_wr = is_queue ? r_head - POS_W'(1) : cnt[POS_W-1:0];
        end else begin
            pos_wr = is_queue ? r_head + cnt[POS_W-1:0] : cnt[POS_W-1:0];
        end
        addr_a = ADDR_W'({r_sel, pos_top});
        addr_b = ADDR_W'({r_sel, pos_second});
        addr_w = ADDR_W'({r_sel, pos_wr});
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_in.command == CMD_SWAP && cnt >= CNT_W'(2)) begin
                    n_state = ST_SWAP2;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWAP2: n_state = ST_SWAP3;
            ST_SWAP3: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory access, store updates and result
    always_comb begin
        n_counts  = r_counts;
        n_head    = r_head;
        n_sel     = r_sel;
        n_hold    = r_hold;
        n_done    = 1'b0;
        n_res     = r_res;
        n_valid   = r_valid;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_addr_w;
        mem_wdata = r_in.value;
        mem_raddr = addr_a;
        case (r_state)
            ST_IDLE: begin
                mem_raddr = addr_a;
            end
            ST_EXEC: begin
                mem_raddr = r_addr_b;
                n_res     = '0;
                n_valid   = 1'b0;
                n_status  = STAT_OK;
                n_done    = 1'b1;
                case (r_in.command)
                    CMD_POP: begin
                        if (cnt == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_res           = mem_rdata;
                            n_valid         = 1'b1;
                            n_counts[r_sel] = cnt_m1;
                            if (is_queue) begin
                                n_head = r_head + POS_W'(1);
                            end
                        end
                    end
                    CMD_PUSH: begin
                        if (cnt >= CNT_W'(STORE_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            n_counts[r_sel] = cnt + CNT_W'(1);
                        end
                    end
                    CMD_DUP: begin
                        if (cnt == '0) begin
                            n_status = STAT_EMPTY;
                        end else if (cnt >= CNT_W'(STORE_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_res           = mem_rdata;
                            n_valid         = 1'b1;
                            mem_we          = 1'b1;
                            mem_wdata       = mem_rdata;
                            n_counts[r_sel] = cnt + CNT_W'(1);
                            if (is_queue) begin
                                n_head = r_head - POS_W'(1);
                            end
                        end
                    end
                    CMD_SWAP: begin
                        if (cnt < CNT_W'(2)) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            // hold the top entry, result waits for the writes
                            n_hold = mem_rdata;
                            n_done = 1'b0;
                        end
                    end
                    CMD_SELECT: begin
                        if (r_in.store_choice >= STORE_W'(STORE_COUNT)) begin
                            n_status = STAT_BAD;
                        end else begin
                            n_sel = r_in.store_choice;
                        end
                    end
                    CMD_CLEAR: begin
                        for (int i = 0; i < STORE_COUNT; i++) begin
                            n_counts[i] = '0;
                        end
                        n_head = '0;
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
            ST_SWAP2: begin
                // second entry moves to the top position
                mem_we    = 1'b1;
                mem_waddr = r_addr_a;
                mem_wdata = mem_rdata;
            end
            ST_SWAP3: begin
                // held top entry moves to the second position
                mem_we    = 1'b1;
                mem_waddr = r_addr_b;
                mem_wdata = r_hold;
                n_done    = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_sel   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < STORE_COUNT; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_sel    <= n_sel;
            r_done   <= n_done;
            r_counts <= n_counts;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in     <= i_cmd;
            r_addr_a <= addr_a;
            r_addr_b <= addr_b;
            r_addr_w <= addr_w;
        end
        r_hold   <= n_hold;
        r_res    <= n_res;
        r_valid  <= n_valid;
        r_status <= n_status;
    end

    msqs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // drive the ports
    assign busy                 = (r_state != ST_IDLE);
    assign o_done               = r_done;
    assign o_result.value_res   = r_res;
    assign o_result.value_valid = r_valid;
    assign o_result.status      = r_status;
    assign o_result.fill_count  = r_counts[r_sel];

    // result transfer only comes back in idle, after an accepted command
    `MSQS_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `MSQS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy && !o_done)
    `MSQS_ASSERT_SAME(a_valid_ok, i_clk, i_rst_n, o_done && o_result.value_valid, o_result.status == STAT_OK)
    `MSQS_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, o_result.fill_count <= 9'(STORE_DEPTH))

endmodule

// ===== test/tb_multi_stack_queue_store.sv =====
// Testbench for the stack and queue store: table and random command transfers vs. a predictor
module tb_multi_stack_queue_store;
    timeunit 1ns;
    timeprecision 1ps;

    import msqs_pkg::*;

    // Command codes outside the package enum, accepted and ignored by the block
    localparam logic [2:0] CMD_UNUSED6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED7 = 3'd7;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_cmd = '0;
    logic o_done;
    t_out o_result;

    multi_stack_queue_store i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stimulus row: command transfer plus an optional typed-in result
    typedef struct {
        t_in  item;
        bit   has_want;
        t_out want;
    } t_stim_row;

    t_stim_row stim_rows [$];
    t_out      pending_results [$];
    int        mismatch_cnt = 0;
    int        stall_cycles = 0;

    // Predictor state: entry memory, fill per store, queue front, selection
    logic [31:0] store_mem  [STORE_COUNT][STORE_DEPTH];
    logic [8:0]  store_fill [STORE_COUNT];
    logic [7:0]  q_head;
    logic [4:0]  cur_store;

    function automatic void add_row(logic [2:0] cmd, logic [31:0] val, logic [4:0] choice,
                                    bit has_want = 1'b0, logic [31:0] w_val = '0,
                                    bit w_vld = 1'b0, logic [1:0] w_st = STAT_OK,
                                    logic [8:0] w_fill = '0);
        t_stim_row r;
        r.item.command      = cmd;
        r.item.value        = val;
        r.item.store_choice = choice;
        r.has_want          = has_want;
        r.want.value_res    = w_val;
        r.want.value_valid  = w_vld;
        r.want.status       = w_st;
        r.want.fill_count   = w_fill;
        stim_rows = {stim_rows, r};
    endfunction

    // Apply one command to the predictor state and return the result it gives
    function automatic t_out apply_store_cmd(t_in it);
        t_out        r;
        logic [4:0]  s;
        logic [8:0]  n;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [31:0] tmp;
        bit          is_q;
        r    = '0;
        s    = cur_store;
        n    = store_fill[s];
        is_q = (s == QUEUE_SLOT);
        case (it.command)
            CMD_POP: begin
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    pa = is_q ? q_head : n[7:0] - 8'd1;
                    r.value_res   = store_mem[s][pa];
                    r.value_valid = 1'b1;
                    if (is_q) q_head = q_head + 8'd1;
                    store_fill[s] = n - 9'd1;
                end
            end
            CMD_PUSH: begin
                if (n == STORE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    pa = is_q ? q_head + n[7:0] : n[7:0];
                    store_mem[s][pa] = it.value;
                    store_fill[s] = n + 9'd1;
                end
            end
            CMD_DUP: begin
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else if (n == STORE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // queue: copy goes in front of the head; stack: copy goes on top
                    pa = is_q ? q_head : n[7:0] - 8'd1;
                    r.value_res   = store_mem[s][pa];
                    r.value_valid = 1'b1;
                    if (is_q) begin
                        q_head = q_head - 8'd1;
                        store_mem[s][q_head] = r.value_res;
                    end else begin
                        store_mem[s][n[7:0]] = r.value_res;
                    end
                    store_fill[s] = n + 9'd1;
                end
            end
            CMD_SWAP: begin
                if (n < 2) begin
                    r.status = STAT_EMPTY;
                end else begin
                    pa  = is_q ? q_head : n[7:0] - 8'd1;
                    pb  = is_q ? q_head + 8'd1 : n[7:0] - 8'd2;
                    tmp = store_mem[s][pa];
                    store_mem[s][pa] = store_mem[s][pb];
                    store_mem[s][pb] = tmp;
                end
            end
            CMD_SELECT: begin
                if (it.store_choice >= STORE_COUNT) r.status = STAT_BAD;
                else cur_store = it.store_choice;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < STORE_COUNT; i++) store_fill[i] = '0;
                q_head = '0;
            end
            default: begin
            end
        endcase
        r.fill_count = store_fill[cur_store];
        return r;
    endfunction

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected result value=%h valid=%b status=%0d fill=%0d",
                             o_result.value_res, o_result.value_valid, o_result.status,
                             o_result.fill_count);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.value_res !== want.value_res ||
                    o_result.value_valid !== want.value_valid ||
                    o_result.status !== want.status ||
                    o_result.fill_count !== want.fill_count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("ERROR: exp value=%h valid=%b status=%0d fill=%0d",
                                 want.value_res, want.value_valid, want.status,
                                 want.fill_count);
                        $display("       got value=%h valid=%b status=%0d fill=%0d",
                                 o_result.value_res, o_result.value_valid,
                                 o_result.status, o_result.fill_count);
                    end
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int          dir_n;
        int          total;
        int          idle_pct;
        int          k;
        int          pick;
        int          stk;
        bit          q_filled;
        bit          s_filled;
        logic [2:0]  op;
        logic [4:0]  choice;
        t_out        predicted;

        for (int i = 0; i < STORE_COUNT; i++) begin
            store_fill[i] = '0;
            for (int j = 0; j < STORE_DEPTH; j++) store_mem[i][j] = '0;
        end
        q_head    = '0;
        cur_store = '0;

        // Directed table: empty and short cases, extremes, bad selects, clear
        add_row(CMD_POP,     '0,           '0, 1'b1, '0,           1'b0, STAT_EMPTY, 9'd0);
        add_row(CMD_DUP,     '0,           '0, 1'b1, '0,           1'b0, STAT_EMPTY, 9'd0);
        add_row(CMD_PUSH,    32'h7FFFFFFF, '0, 1'b1, '0,           1'b0, STAT_OK,    9'd1);
        add_row(CMD_SWAP,    '0,           '0, 1'b1, '0,           1'b0, STAT_EMPTY, 9'd1);
        add_row(CMD_PUSH,    32'h80000000, '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_SWAP,    '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_POP,     '0,           '0, 1'b1, 32'h7FFFFFFF, 1'b1, STAT_OK,    9'd1);
        add_row(CMD_DUP,     '0,           '0, 1'b1, 32'h80000000, 1'b1, STAT_OK,    9'd2);
        add_row(CMD_UNUSED6, '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_UNUSED7, '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_SELECT,  '0,        5'd31, 1'b1, '0,           1'b0, STAT_BAD,   9'd2);
        add_row(CMD_SELECT,  '0, 5'(STORE_COUNT), 1'b1, '0,        1'b0, STAT_BAD,   9'd2);
        add_row(CMD_SELECT,  '0, 5'(QUEUE_SLOT),  1'b1, '0,        1'b0, STAT_OK,    9'd0);
        add_row(CMD_POP,     '0,           '0, 1'b1, '0,           1'b0, STAT_EMPTY, 9'd0);
        add_row(CMD_DUP,     '0,           '0, 1'b1, '0,           1'b0, STAT_EMPTY, 9'd0);
        add_row(CMD_PUSH,    32'hFFFFFFFF, '0, 1'b1, '0,           1'b0, STAT_OK,    9'd1);
        add_row(CMD_PUSH,    '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_SWAP,    '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd2);
        add_row(CMD_DUP,     '0,           '0, 1'b1, '0,           1'b1, STAT_OK,    9'd3);
        add_row(CMD_POP,     '0,           '0, 1'b1, '0,           1'b1, STAT_OK,    9'd2);
        add_row(CMD_POP,     '0,           '0, 1'b1, '0,           1'b1, STAT_OK,    9'd1);
        add_row(CMD_POP,     '0,           '0, 1'b1, 32'hFFFFFFFF, 1'b1, STAT_OK,    9'd0);
        add_row(CMD_SELECT,  '0, 5'(STORE_COUNT - 1));
        add_row(CMD_PUSH,    32'h5A5A5A5A, '0);
        add_row(CMD_CLEAR,   '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd0);
        add_row(CMD_SELECT,  '0,           '0, 1'b1, '0,           1'b0, STAT_OK,    9'd0);
        dir_n = stim_rows.size();

        // Random part: bursts on one store, plus one queue fill and one stack fill
        q_filled = 1'b0;
        s_filled = 1'b0;
        while (stim_rows.size() < dir_n + RANDOM_ITEMS) begin
            if (!q_filled && stim_rows.size() >= dir_n + 100) begin
                q_filled = 1'b1;
                add_row(CMD_SELECT, $urandom, 5'(QUEUE_SLOT));
                // move the head off zero first so the ring wraps while full
                k = $urandom_range(3, 40);
                repeat (k) add_row(CMD_PUSH, $urandom, 5'($urandom_range(0, 31)));
                repeat (k) add_row(CMD_POP, $urandom, 5'($urandom_range(0, 31)));
                repeat (STORE_DEPTH + 2) add_row(CMD_PUSH, $urandom, 5'($urandom_range(0, 31)));
                add_row(CMD_DUP, $urandom, 5'($urandom_range(0, 31)));
                add_row(CMD_SWAP, $urandom, 5'($urandom_range(0, 31)));
                repeat (12) add_row($urandom_range(0, 1) ? CMD_POP : CMD_DUP, $urandom,
                                    5'($urandom_range(0, 31)));
                add_row(CMD_CLEAR, $urandom, 5'($urandom_range(0, 31)));
            end else if (!s_filled && stim_rows.size() >= dir_n + 450) begin
                s_filled = 1'b1;
                stk = $urandom_range(0, STORE_COUNT - 2);
                if (stk >= QUEUE_SLOT) stk = stk + 1;
                add_row(CMD_SELECT, $urandom, 5'(stk));
                repeat (STORE_DEPTH + 1) add_row(CMD_PUSH, $urandom, 5'($urandom_range(0, 31)));
                add_row(CMD_DUP, $urandom, 5'($urandom_range(0, 31)));
                add_row(CMD_SWAP, $urandom, 5'($urandom_range(0, 31)));
                repeat (12) add_row($urandom_range(0, 1) ? CMD_POP : CMD_DUP, $urandom,
                                    5'($urandom_range(0, 31)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) choice = 5'(QUEUE_SLOT);
                else if (pick < 40) choice = 5'($urandom_range(STORE_COUNT, 31));
                else if (pick < 50) choice = $urandom_range(0, 1) ? 5'(STORE_COUNT - 1) : 5'd0;
                else choice = 5'($urandom_range(0, STORE_COUNT - 1));
                add_row(CMD_SELECT, $urandom, choice);
                repeat ($urandom_range(4, 40)) begin
                    pick   = $urandom_range(0, 99);
                    choice = 5'($urandom_range(0, 31));
                    if (pick < 40) op = CMD_PUSH;
                    else if (pick < 62) op = CMD_POP;
                    else if (pick < 75) op = CMD_DUP;
                    else if (pick < 87) op = CMD_SWAP;
                    else if (pick < 90) op = CMD_CLEAR;
                    else if (pick < 93) op = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
                    else op = CMD_SELECT;
                    add_row(op, $urandom, choice);
                end
            end
        end
        total = stim_rows.size();

        // Hold reset at the start, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drive each transfer; sender gaps are short in the first third, long in the second, none in the last
        for (int i = 0; i < total; i++) begin
            idle_pct = (i < total / 3) ? 13 : (i < 2 * total / 3) ? 81 : 0;
            while ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
            start <= 1'b1;
            i_cmd <= stim_rows[i].item;
            do @(posedge i_clk); while (busy);
            predicted = apply_store_cmd(stim_rows[i].item);
            if (stim_rows[i].has_want) predicted = stim_rows[i].want;
            pending_results = {pending_results, predicted};
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
